FILE: hw/rtl/sgn_pkg.sv
// ----------------------------------------------------------------------------
// sgn_pkg
// Shared widths, constants and controller/datapath interface types for the
// SOM Gaussian neighbourhood row core.
// ----------------------------------------------------------------------------
package sgn_pkg;

  localparam int MAX_GRID    = 64;
  localparam int WEIGHT_BITS = 16;

  localparam int WIN_W      = 13;  // winner index
  localparam int COL_W      = 6;   // row / column number
  localparam int GRID_W     = 7;   // grid_size register
  localparam int RAD_W      = 16;  // radius_q8_8 register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int D2_W      = 2 * COL_W + 1;  // dx^2 + dy^2
  localparam int REM_W     = 2 * RAD_W;      // divider remainder / divisor
  localparam int QUOT_W    = 21;             // exponent argument, Q5.16
  localparam int FRAC_W    = 16;
  localparam int NEXP_W    = QUOT_W - FRAC_W;
  localparam int STEPS_W   = 5;
  localparam int FAR_SHIFT = 10;             // d2 << 10 >= r^2 means n >= 32
  localparam int WM1_W     = 12;             // winner index minus one

  localparam logic [STEPS_W-1:0] WXY_STEPS = STEPS_W'(WM1_W);
  localparam logic [STEPS_W-1:0] ARG_STEPS = STEPS_W'(QUOT_W);

  // Taylor series of exp(-f)
  localparam int               TERMS      = 14;
  localparam int               K_W        = 4;
  localparam int               TERM_W     = 32;
  localparam int               TERM_BYTES = TERM_W / 8;
  localparam int               ACC_W      = 33;
  localparam logic [ACC_W-1:0] ONE_Q32    = ACC_W'(64'h1_0000_0000);
  localparam logic [31:0]      E1_Q32     = 32'd1580030169;  // exp(-1), Q0.32

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd1;

  typedef struct packed {
    logic accept;
    logic wdiv_start;
    logic cap_wxy;
    logic calc_d2;
    logic set_short;
    logic adiv_start;
    logic series_init;
    logic term_mul;
    logic term_div;
    logic term_acc;
    logic e1_mul;
    logic col_next;
    logic emit_ok;
    logic emit_bad;
  } sgn_cmd_t;

  typedef struct packed {
    logic bad;
    logic short_cut;
    logic div_done;
    logic k_last;
    logic n_zero;
    logic col_last;
  } sgn_stat_t;

endpackage

FILE: hw/rtl/sgn_div.sv
// ----------------------------------------------------------------------------
// sgn_div
// Restoring divider, one quotient bit per cycle. Shared between the winner
// position split and the exponent argument.
// ----------------------------------------------------------------------------
module sgn_div
  import sgn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [STEPS_W-1:0] steps_i,
  input  logic [REM_W-1:0]   rem_init_i,
  input  logic [QUOT_W-1:0]  dq_init_i,
  input  logic [REM_W-1:0]   divisor_i,
  output logic               done_o,
  output logic [QUOT_W-1:0]  quot_o,
  output logic [REM_W-1:0]   rem_o
);

  logic               running_q, running_d;
  logic               done_q, done_d;
  logic [STEPS_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0]   rem_q, div_q;
  logic [QUOT_W-1:0]  dq_q;

  logic [REM_W:0]     rem_sh;
  logic               ge;
  logic [REM_W:0]     rem_sub;

  // dividend bits enter the remainder from the top of dq, quotient bits
  // enter dq from the bottom
  always_comb begin
    rem_sh  = {rem_q, dq_q[QUOT_W-1]};
    ge      = (rem_sh >= {1'b0, div_q});
    rem_sub = rem_sh - {1'b0, div_q};
  end

  always_comb begin
    running_d = running_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    if (start_i) begin
      running_d = 1'b1;
      cnt_d     = steps_i;
    end else if (running_q) begin
      cnt_d = cnt_q - STEPS_W'(1);
      if (cnt_q == STEPS_W'(1)) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      dq_q  <= dq_init_i;
      div_q <= divisor_i;
    end else if (running_q) begin
      rem_q <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      dq_q  <= {dq_q[QUOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;
  assign rem_o  = rem_q;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !running_q)
    else $error("divider restarted while running");

  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

endmodule

FILE: hw/rtl/sgn_dpath.sv
// ----------------------------------------------------------------------------
// sgn_dpath
// Datapath: configuration registers, request check, distance, exponent
// argument, exp(-f) series and exp(-1) powers, weight rounding.
// ----------------------------------------------------------------------------
module sgn_dpath
  import sgn_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sgn_cmd_t               cmd_i,
  output sgn_stat_t              stat_o,
  input  logic [WIN_W-1:0]       winner_index_i,
  input  logic [COL_W-1:0]       row_number_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic [COL_W-1:0]       column_number_o,
  output logic [WEIGHT_BITS-1:0] weight_o,
  output logic                   last_in_row_o,
  output logic                   bad_request_o
);

  localparam int               SH    = 32 - WEIGHT_BITS;
  localparam logic [ACC_W:0]   ROUND = (SH > 0) ? ((ACC_W+1)'(1) << (SH - 1)) : '0;
  localparam logic [ACC_W:0]   MAXW  = ((ACC_W+1)'(1) << WEIGHT_BITS) - (ACC_W+1)'(1);

  logic [GRID_W-1:0] grid_q;
  logic [RAD_W-1:0]  rad_q;

  logic [WIN_W-1:0]  w_q;
  logic [COL_W-1:0]  row_q;
  logic [REM_W-1:0]  rsq_q;
  logic [COL_W-1:0]  wx_q, wy_q, col_q;
  logic [D2_W-1:0]   d2_q;
  logic [NEXP_W-1:0] n_q;
  logic [FRAC_W-1:0] f_q;
  logic [ACC_W-1:0]  t_q, acc_q;
  logic [TERM_W-1:0] x_q;
  logic [K_W-1:0]    k_q, kr_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GRID_W'(16);
      rad_q  <= RAD_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GRID_SIZE: grid_q <= cfg_wdata_i[GRID_W-1:0];
        CFG_RADIUS:    rad_q  <= cfg_wdata_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // request check
  logic [2*GRID_W-1:0] gsq;
  logic [WIN_W-1:0]    wm1;
  always_comb begin
    gsq = grid_q * grid_q;
    wm1 = w_q - WIN_W'(1);
  end

  assign stat_o.bad = (grid_q == '0) || (grid_q > GRID_W'(MAX_GRID)) || (w_q == '0) ||
                      ((2*GRID_W)'(w_q) > gsq) || (GRID_W'(row_q) >= grid_q);

  // distance
  logic [COL_W-1:0]   dx, dy;
  logic [2*COL_W-1:0] dx2, dy2;
  always_comb begin
    dx  = (col_q > wx_q) ? col_q - wx_q : wx_q - col_q;
    dy  = (row_q > wy_q) ? row_q - wy_q : wy_q - row_q;
    dx2 = dx * dx;
    dy2 = dy * dy;
  end

  logic [REM_W-1:0] d2_sh;
  assign d2_sh            = REM_W'({d2_q, FAR_SHIFT'(0)});
  assign stat_o.short_cut = (d2_sh >= rsq_q);  // also true for a zero radius

  // shared divider
  logic               div_done;
  logic [QUOT_W-1:0]  div_quot;
  logic [REM_W-1:0]   div_rem;
  logic [STEPS_W-1:0] div_steps;
  logic [REM_W-1:0]   div_rem_init, div_divisor;
  logic [QUOT_W-1:0]  div_dq_init;

  always_comb begin
    if (cmd_i.wdiv_start) begin
      div_steps    = WXY_STEPS;
      div_rem_init = '0;
      div_dq_init  = {wm1[WM1_W-1:0], (QUOT_W-WM1_W)'(0)};
      div_divisor  = REM_W'(grid_q);
    end else begin
      div_steps    = ARG_STEPS;
      div_rem_init = d2_sh;
      div_dq_init  = '0;
      div_divisor  = rsq_q;
    end
  end

  sgn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.wdiv_start | cmd_i.adiv_start),
    .steps_i    (div_steps),
    .rem_init_i (div_rem_init),
    .dq_init_i  (div_dq_init),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign stat_o.div_done = div_done;

  // series term: multiply by f, then divide by k one byte a cycle
  logic [ACC_W+FRAC_W-1:0] tprod;
  logic [ACC_W+31:0]       eprod;
  logic [K_W-1:0]          kr;
  logic [K_W:0]            ktmp;
  logic [7:0]              qbyte;

  always_comb begin
    tprod = t_q * f_q;
    eprod = acc_q * E1_Q32;
  end

  always_comb begin
    kr    = kr_q;
    ktmp  = '0;
    qbyte = '0;
    for (int i = 7; i >= 0; i--) begin
      ktmp = {kr, x_q[TERM_W-8+i]};
      if (ktmp >= {1'b0, k_q}) begin
        qbyte[i] = 1'b1;
        ktmp     = ktmp - {1'b0, k_q};
      end
      kr = ktmp[K_W-1:0];
    end
  end

  assign stat_o.k_last   = (k_q == K_W'(TERMS));
  assign stat_o.n_zero   = (n_q == '0);
  assign stat_o.col_last = (GRID_W'(col_q) == grid_q - GRID_W'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      w_q   <= winner_index_i;
      row_q <= row_number_i;
      rsq_q <= rad_q * rad_q;
    end
    if (cmd_i.cap_wxy) begin
      wx_q  <= div_rem[COL_W-1:0];
      wy_q  <= div_quot[COL_W-1:0];
      col_q <= '0;
    end else if (cmd_i.col_next) begin
      col_q <= col_q + COL_W'(1);
    end
    if (cmd_i.calc_d2) begin
      d2_q <= D2_W'(dx2) + D2_W'(dy2);
    end
    if (cmd_i.set_short) begin
      acc_q <= ((rad_q == '0) && (d2_q == '0)) ? ONE_Q32 : '0;
    end else if (cmd_i.series_init) begin
      n_q   <= div_quot[QUOT_W-1:FRAC_W];
      f_q   <= div_quot[FRAC_W-1:0];
      t_q   <= ONE_Q32;
      acc_q <= ONE_Q32;
      k_q   <= K_W'(1);
    end else if (cmd_i.term_mul) begin
      x_q  <= tprod[FRAC_W+TERM_W-1:FRAC_W];
      kr_q <= '0;
    end else if (cmd_i.term_div) begin
      x_q  <= {x_q[TERM_W-9:0], qbyte};
      kr_q <= kr;
    end else if (cmd_i.term_acc) begin
      // alternating series with shrinking terms stays within 0..1.0
      t_q   <= ACC_W'(x_q);
      acc_q <= k_q[0] ? acc_q - ACC_W'(x_q) : acc_q + ACC_W'(x_q);
      k_q   <= k_q + K_W'(1);
    end else if (cmd_i.e1_mul) begin
      acc_q <= eprod[ACC_W+31:32];
      n_q   <= n_q - NEXP_W'(1);
    end
  end

  // rounding to the output width, 1.0 saturates
  logic [ACC_W:0] rsum, rshift;
  logic [WEIGHT_BITS-1:0] wcalc;
  always_comb begin
    rsum   = {1'b0, acc_q} + ROUND;
    rshift = rsum >> SH;
    wcalc  = (rshift > MAXW) ? MAXW[WEIGHT_BITS-1:0] : rshift[WEIGHT_BITS-1:0];
  end

  assign column_number_o = cmd_i.emit_bad ? '0 : col_q;
  assign weight_o        = cmd_i.emit_bad ? '0 : wcalc;
  assign last_in_row_o   = cmd_i.emit_bad | stat_o.col_last;
  assign bad_request_o   = cmd_i.emit_bad;

  a_acc_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_ok |-> (acc_q <= ONE_Q32))
    else $error("exponential accumulator above 1.0");

endmodule

FILE: hw/rtl/sgn_ctrl.sv
// ----------------------------------------------------------------------------
// sgn_ctrl
// Controller: sequences request check, position split, and per column the
// distance, shortcut or argument division, series terms and exp(-1) powers.
// ----------------------------------------------------------------------------
module sgn_ctrl
  import sgn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  sgn_stat_t stat_i,
  output sgn_cmd_t  cmd_o,
  output logic      busy_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_WDIV  = 4'd2;
  localparam logic [3:0] ST_CELL  = 4'd3;
  localparam logic [3:0] ST_FAR   = 4'd4;
  localparam logic [3:0] ST_ADIV  = 4'd5;
  localparam logic [3:0] ST_TMUL  = 4'd6;
  localparam logic [3:0] ST_TDIV  = 4'd7;
  localparam logic [3:0] ST_TACC  = 4'd8;
  localparam logic [3:0] ST_EMUL  = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;
  localparam logic [3:0] ST_BAD   = 4'd11;

  localparam int BYTE_W = $clog2(TERM_BYTES);

  logic [3:0]        state_q, state_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  sgn_cmd_t          cmd;

  always_comb begin
    state_d = state_q;
    byte_d  = byte_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd.accept = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.bad) begin
          state_d = ST_BAD;
        end else begin
          cmd.wdiv_start = 1'b1;
          state_d        = ST_WDIV;
        end
      end
      ST_WDIV: begin
        if (stat_i.div_done) begin
          cmd.cap_wxy = 1'b1;
          state_d     = ST_CELL;
        end
      end
      ST_CELL: begin
        cmd.calc_d2 = 1'b1;
        state_d     = ST_FAR;
      end
      ST_FAR: begin
        if (stat_i.short_cut) begin
          cmd.set_short = 1'b1;
          state_d       = ST_OUT;
        end else begin
          cmd.adiv_start = 1'b1;
          state_d        = ST_ADIV;
        end
      end
      ST_ADIV: begin
        if (stat_i.div_done) begin
          cmd.series_init = 1'b1;
          state_d         = ST_TMUL;
        end
      end
      ST_TMUL: begin
        cmd.term_mul = 1'b1;
        byte_d       = '0;
        state_d      = ST_TDIV;
      end
      ST_TDIV: begin
        cmd.term_div = 1'b1;
        byte_d       = byte_q + BYTE_W'(1);
        if (byte_q == BYTE_W'(TERM_BYTES - 1)) begin
          state_d = ST_TACC;
        end
      end
      ST_TACC: begin
        cmd.term_acc = 1'b1;
        state_d      = stat_i.k_last ? ST_EMUL : ST_TMUL;
      end
      ST_EMUL: begin
        if (stat_i.n_zero) begin
          state_d = ST_OUT;
        end else begin
          cmd.e1_mul = 1'b1;
        end
      end
      ST_OUT: begin
        cmd.emit_ok = 1'b1;
        if (stat_i.col_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd.col_next = 1'b1;
          state_d      = ST_CELL;
        end
      end
      ST_BAD: begin
        cmd.emit_bad = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      byte_q  <= '0;
    end else begin
      state_q <= state_d;
      byte_q  <= byte_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: hw/rtl/som_gaussian_neighborhood_row_core.sv
// ----------------------------------------------------------------------------
// som_gaussian_neighborhood_row_core
// Gaussian neighbourhood weights for one row of a square SOM grid.
// ----------------------------------------------------------------------------
// A rejected request gives its single result. Otherwise the position split runs
// first, then per column either a shortcut weight (zero radius or exponent >= 32)
// or the argument division, the 14-term series and n exp(-1) powers (n = 0..31).
// One request at a time, busy high until the last result; results never stall.
// Reset (rst_ni low, asynchronous) returns to idle with grid 16 and radius 1.0.
module som_gaussian_neighborhood_row_core
  import sgn_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [WIN_W-1:0]       winner_index_i,
  input  logic [COL_W-1:0]       row_number_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic                   result_valid_o,
  output logic [COL_W-1:0]       column_number_o,
  output logic [WEIGHT_BITS-1:0] weight_o,
  output logic                   last_in_row_o,
  output logic                   bad_request_o
);

  sgn_cmd_t  cmd;
  sgn_stat_t stat;

  sgn_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  sgn_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .winner_index_i  (winner_index_i),
    .row_number_i    (row_number_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .column_number_o (column_number_o),
    .weight_o        (weight_o),
    .last_in_row_o   (last_in_row_o),
    .bad_request_o   (bad_request_o)
  );

  assign result_valid_o = cmd.emit_ok | cmd.emit_bad;

  a_valid_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe outside a transaction");

  a_accept_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("result straight after acceptance");

  a_bad_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && bad_request_o) |=> !busy)
    else $error("rejected request did not end the transaction");

endmodule

FILE: tb/sv/som_gaussian_neighborhood_row_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// som_gaussian_neighborhood_row_core_tb
// Self-checking bench for the Gaussian neighbourhood row core. Requests go in
// through the start/busy handshake and the weights of each row are checked
// against a fixed-point predictor held in a small scoreboard. A directed part
// covers grid corners, rejected requests, zero and maximum radius and the
// grid-size limits. Randomised register settings follow, with the sender
// idling at several rates.
// ----------------------------------------------------------------------------
module som_gaussian_neighborhood_row_core_tb;
  import sgn_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned TAIL_CYCLES = 200;  // longer than one slow column
  localparam int unsigned MAX_REPORTS = 10;
  localparam int          RND_SHIFT   = 32 - WEIGHT_BITS;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [COL_W-1:0]       column;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   last_in_row;
    logic                   bad_request;
  } row_result_t;

  class row_weight_sb;
    logic [GRID_W-1:0] grid_size;
    logic [RAD_W-1:0]  radius;
    row_result_t       weights_q[$];
    int unsigned       fail_count;
    int unsigned       requests;
    int unsigned       rejected;
    int unsigned       results_seen;

    function new();
      grid_size    = 7'd16;
      radius       = 16'd256;
      fail_count   = 0;
      requests     = 0;
      rejected     = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_SIZE: grid_size = data[GRID_W-1:0];
        CFG_RADIUS:    radius    = data[RAD_W-1:0];
        default: ;
      endcase
    endfunction

    // exp(-f), f in Q0.16, by a 14-term alternating series; Q0.32 result
    function longint unsigned exp_neg_frac(longint unsigned f);
      longint          acc;
      longint unsigned term;
      acc  = 64'sd1 <<< 32;
      term = 64'd1 << 32;
      for (int k = 1; k <= 14; k++) begin
        term = ((term * f) >> 16) / longint'(k);
        if (k % 2) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      return longint'(acc);
    endfunction

    function logic [WEIGHT_BITS-1:0] gauss_weight(longint unsigned d2);
      longint unsigned r, arg, n_int, e, e_one, max_w;
      max_w = (64'd1 << WEIGHT_BITS) - 1;
      r     = radius;
      if (r == 0) begin
        e = (d2 == 0) ? (64'd1 << 32) : 64'd0;
      end else begin
        arg   = (d2 << 31) / (r * r);
        n_int = arg >> 16;
        if (n_int >= 32) begin
          e = 0;
        end else begin
          e_one = exp_neg_frac(64'd65536);
          e     = exp_neg_frac(arg & 64'hFFFF);
          for (longint unsigned i = 0; i < n_int; i++) e = (e * e_one) >> 32;
        end
      end
      e = (e + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
      if (e > max_w) e = max_w;
      return e[WEIGHT_BITS-1:0];
    endfunction

    function void note_request(logic [WIN_W-1:0] winner, logic [COL_W-1:0] row);
      int          g, w, wx, wy, dx, dy;
      row_result_t res;
      g = grid_size;
      w = winner;
      requests++;
      if (g == 0 || g > MAX_GRID || w == 0 || w > g * g || int'(row) >= g) begin
        res.column      = '0;
        res.weight      = '0;
        res.last_in_row = 1'b1;
        res.bad_request = 1'b1;
        weights_q.push_back(res);
        rejected++;
        return;
      end
      wx = (w - 1) % g;
      wy = (w - 1) / g;
      dy = (int'(row) > wy) ? int'(row) - wy : wy - int'(row);
      for (int c = 0; c < g; c++) begin
        dx = (c > wx) ? c - wx : wx - c;
        res.column      = COL_W'(c);
        res.weight      = gauss_weight(longint'(dx * dx + dy * dy));
        res.last_in_row = (c == g - 1);
        res.bad_request = 1'b0;
        weights_q.push_back(res);
      end
    endfunction

    function void check_result(row_result_t got);
      row_result_t exp_res;
      results_seen++;
      if (weights_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("[%0t] unexpected result: col %0d weight %0d last %0b bad %0b",
                   $realtime, got.column, got.weight, got.last_in_row, got.bad_request);
        return;
      end
      exp_res = weights_q.pop_front();
      if (got.column !== exp_res.column || got.weight !== exp_res.weight ||
          got.last_in_row !== exp_res.last_in_row ||
          got.bad_request !== exp_res.bad_request) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("[%0t] mismatch: exp c%0d w%0d l%0b b%0b, got c%0d w%0d l%0b b%0b",
                   $realtime, exp_res.column, exp_res.weight, exp_res.last_in_row,
                   exp_res.bad_request, got.column, got.weight, got.last_in_row,
                   got.bad_request);
      end
    endfunction
  endclass

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   start          = 1'b0;
  logic                   busy;
  logic [WIN_W-1:0]       winner_index_i = '0;
  logic [COL_W-1:0]       row_number_i   = '0;
  logic                   cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i    = '0;
  logic                   result_valid_o;
  logic [COL_W-1:0]       column_number_o;
  logic [WEIGHT_BITS-1:0] weight_o;
  logic                   last_in_row_o;
  logic                   bad_request_o;

  row_weight_sb sb = new();
  int unsigned  cycle_count       = 0;
  int unsigned  sender_idle_pct   = 0;
  int unsigned  reg_writes        = 0;

  som_gaussian_neighborhood_row_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .winner_index_i  (winner_index_i),
    .row_number_i    (row_number_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_valid_o  (result_valid_o),
    .column_number_o (column_number_o),
    .weight_o        (weight_o),
    .last_in_row_o   (last_in_row_o),
    .bad_request_o   (bad_request_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // results cannot be held off: take every strobe
  always @(posedge clk_i) begin
    row_result_t got;
    if (rst_ni && result_valid_o) begin
      got.column      = column_number_o;
      got.weight      = weight_o;
      got.last_in_row = last_in_row_o;
      got.bad_request = bad_request_o;
      sb.check_result(got);
    end
  end

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    reg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (sb.weights_q.size() != 0 || busy);
  endtask

  task automatic send_request(input logic [WIN_W-1:0] w, input logic [COL_W-1:0] r);
    @(posedge clk_i);
    // either hold start high through busy, or idle once the core is free
    if ($urandom_range(99) < sender_idle_pct) begin
      while (busy || $urandom_range(99) < sender_idle_pct) @(posedge clk_i);
    end
    start          <= 1'b1;
    winner_index_i <= w;
    row_number_i   <= r;
    do @(posedge clk_i); while (busy);
    sb.note_request(w, r);
    start <= 1'b0;
  endtask

  // mostly in-grid requests, the rest rejected for a row outside the grid, a winner beyond it or a zero winner
  task automatic random_request();
    int          g;
    int unsigned sel;
    logic [WIN_W-1:0] w;
    logic [COL_W-1:0] r;
    g   = sb.grid_size;
    sel = $urandom_range(99);
    w   = WIN_W'($urandom_range(g * g, 1));
    r   = COL_W'($urandom_range(g - 1, 0));
    if (sel >= 94 && g < MAX_GRID) begin
      r = COL_W'($urandom_range(63, g));
    end else if (sel >= 88) begin
      w = WIN_W'($urandom_range(8191, g * g + 1));
      r = COL_W'($urandom_range(63, 0));
    end else if (sel >= 82) begin
      w = '0;
      r = COL_W'($urandom_range(63, 0));
    end
    send_request(w, r);
  endtask

  initial begin
    int unsigned idle_levels[3];
    int unsigned sel, n_items;
    logic [CFG_DATA_W-1:0] g_val, r_val;

    idle_levels = '{38, 75, 0};
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    sender_idle_pct = 38;

    // reset settings: grid 16, radius 1.0
    send_request(13'd1, 6'd0);
    send_request(13'd256, 6'd15);
    send_request(13'd120, 6'd7);
    send_request(13'd0, 6'd0);
    send_request(13'd257, 6'd3);
    send_request(13'd5, 6'd16);
    send_request(13'd8191, 6'd63);

    // full grid, zero radius: only the winner cell is non-zero
    wait_idle();
    apply_reg(CFG_GRID_SIZE, 16'd64);
    apply_reg(CFG_RADIUS, 16'd0);
    send_request(13'd4096, 6'd63);
    send_request(13'd2080, 6'd32);
    send_request(13'd1, 6'd5);

    // maximum radius: every weight near one, every column slow
    wait_idle();
    apply_reg(CFG_RADIUS, 16'hFFFF);
    send_request(13'd4096, 6'd0);

    // single-cell grid
    wait_idle();
    apply_reg(CFG_GRID_SIZE, 16'd1);
    apply_reg(CFG_RADIUS, 16'd1);
    send_request(13'd1, 6'd0);
    send_request(13'd2, 6'd0);
    send_request(13'd1, 6'd1);

    // grid sizes outside the supported range
    wait_idle();
    apply_reg(CFG_GRID_SIZE, 16'd0);
    send_request(13'd1, 6'd0);
    wait_idle();
    apply_reg(CFG_GRID_SIZE, 16'd127);
    send_request(13'd1, 6'd0);
    wait_idle();
    apply_reg(CFG_GRID_SIZE, 16'd65);
    send_request(13'd4096, 6'd63);

    // upper data bits beyond the grid register are dropped; spare indexes ignored
    wait_idle();
    apply_reg(CFG_GRID_SIZE, 16'hFF88);
    apply_reg(CFG_RADIUS, 16'h0280);
    apply_reg(CFG_SPARE_2, 16'hFFFF);
    apply_reg(CFG_SPARE_3, 16'h5A5A);
    send_request(13'd64, 6'd7);
    send_request(13'd28, 6'd3);
    wait_idle();
    apply_reg(CFG_RADIUS, 16'h0001);
    send_request(13'd10, 6'd1);

    foreach (idle_levels[lvl]) begin
      sender_idle_pct = idle_levels[lvl];
      for (int ph = 0; ph < 4; ph++) begin
        wait_idle();
        sel   = $urandom_range(19);
        g_val = (sel == 0) ? 16'd64 : (sel == 1) ? 16'd1 : CFG_DATA_W'($urandom_range(12, 2));
        sel   = $urandom_range(9);
        r_val = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF :
                (sel == 2) ? CFG_DATA_W'($urandom_range(65535, 1)) :
                CFG_DATA_W'($urandom_range(2048, 32));
        apply_reg(CFG_GRID_SIZE, g_val);
        apply_reg(CFG_RADIUS, r_val);
        // full-size rows are slow, so keep them few
        n_items = (g_val == 16'd64) ? 2 : 7;
        repeat (n_items) random_request();
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d requests (%0d rejected), %0d results checked, %0d register writes",
             sb.requests, sb.rejected, sb.results_seen, reg_writes);
    $display("sender idle rates 38/75/0 percent; %0d failures", sb.fail_count);
    if (sb.fail_count == 0 && sb.weights_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sgn_pkg.sv
hw/rtl/sgn_div.sv
hw/rtl/sgn_dpath.sv
hw/rtl/sgn_ctrl.sv
hw/rtl/som_gaussian_neighborhood_row_core.sv
tb/sv/som_gaussian_neighborhood_row_core_tb.sv
